// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the matrix rotate and flip engine.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/mrf_pkg.sv =====
// Package for the matrix rotate and flip engine: widths, codes and shared types.
// Has no dependencies; imported by the address unit and the top level of the block.
`timescale 1ns / 1ps

package mrf_pkg;

  localparam int DIM_W     = 4;
  localparam int ELEM_W    = 32;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_CODE    = 1'b1;

  localparam logic [CODE_W-1:0] XF_ROTATE = 2'd0;
  localparam logic [CODE_W-1:0] XF_FLIP   = 2'd1;
  localparam logic [CODE_W-1:0] XF_NONE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic swap;
    logic row_rev;
    logic col_rev;
  } xform_t;

  localparam xform_t XF_IDENTITY = '{swap: 1'b0, row_rev: 1'b0, col_rev: 1'b0};

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

// ===== src/mrf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies; holds the matrix elements of the engine.
`timescale 1ns / 1ps

module mrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mrf_addr_unit.sv =====
// Address unit: maps an output position to its source store address.
// Depends on mrf_pkg for the transform type and the dimension width.
`timescale 1ns / 1ps

module mrf_addr_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]                 row_idx,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]                 col_idx,
  input  mrf_pkg::xform_t                                                xf,
  input  logic [mrf_pkg::DIM_W-1:0]                                      rows,
  input  logic [mrf_pkg::DIM_W-1:0]                                      cols,
  output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] addr
);

  import mrf_pkg::*;

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int FULLW = IW + DIM_W + 1;

  logic [IW-1:0]    a_idx;
  logic [IW-1:0]    b_idx;
  logic [DIM_W-1:0] row_mirror;
  logic [DIM_W-1:0] col_mirror;
  logic [IW-1:0]    src_row;
  logic [IW-1:0]    src_col;
  logic [FULLW-1:0] full_addr;

  always_comb begin
    a_idx      = xf.swap ? col_idx : row_idx;
    b_idx      = xf.swap ? row_idx : col_idx;
    row_mirror = rows - DIM_W'(1) - DIM_W'(a_idx);
    col_mirror = cols - DIM_W'(1) - DIM_W'(b_idx);
    src_row    = xf.row_rev ? row_mirror[IW-1:0] : a_idx;
    src_col    = xf.col_rev ? col_mirror[IW-1:0] : b_idx;
    full_addr  = FULLW'(src_row) * FULLW'(cols) + FULLW'(src_col);
    addr       = full_addr[AW-1:0];
  end

endmodule

// ===== src/matrix_rotate_flip_engine.sv =====
// Top level of the matrix rotate and flip engine: sequencer, store and output stage.
// Depends on mrf_pkg, mrf_ram, mrf_addr_unit and assert_macros.svh.
//
// A request is taken at a rising edge with start high and busy low. With operation
// at element, element_in is written to the next store entry; entries beyond
// MAX_DIM*MAX_DIM are dropped. With operation at transform code, the code is folded
// into the running transform. A code with final_code set starts emission: busy rises
// and stays high while the address unit issues one store read per cycle for each of
// the result_rows*result_cols positions. The first result passes through the state
// register and the registered store read before it reaches the ports; the results
// then follow one per cycle in row-major order, each shown for one cycle with
// result_valid high; last_element marks the final one. The receiver cannot stall.
// A new request can be taken in the cycle that shows the last result. Afterwards
// the element count and the transform return to their reset values. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the row and column counts
// and is always ready; writes belong in idle periods. Reset clears the sequencer, the
// count and the transform and sets both dimensions to eight; store contents are
// undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_rotate_flip_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic signed [mrf_pkg::ELEM_W-1:0] element_in,
  input  logic [mrf_pkg::CODE_W-1:0]      transform,
  input  logic                            final_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrf_pkg::DIM_W-1:0]       cfg_data,
  output logic                            result_valid,
  output logic [mrf_pkg::DIM_W-1:0]       result_rows,
  output logic [mrf_pkg::DIM_W-1:0]       result_cols,
  output logic signed [mrf_pkg::ELEM_W-1:0] element_out,
  output logic                            last_element
);

  import mrf_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_MAX = (MAX_DIM > 15) ? 15 : MAX_DIM;

  state_t           state;
  state_t           state_next;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] column_count;
  logic [CNT_W-1:0] element_count;
  xform_t           xf;
  xform_t           xf_next;
  logic [IW-1:0]    row_idx;
  logic [IW-1:0]    col_idx;
  logic [DIM_W-1:0] out_rows;
  logic [DIM_W-1:0] out_cols;

  logic [DIM_W-1:0]  rows_c;
  logic [DIM_W-1:0]  cols_c;
  logic              accept;
  logic              load_elem;
  logic              take_code;
  logic              start_emit;
  logic              issue;
  logic              col_last;
  logic              issue_last;
  logic [AW-1:0]     rd_addr;
  logic [ELEM_W-1:0] rd_data;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign rows_c    = clamp_dim(row_count);
  assign cols_c    = clamp_dim(column_count);

  assign accept     = start && !busy;
  assign load_elem  = accept && (operation == OP_ELEMENT) && (element_count < CNT_W'(DEPTH));
  assign take_code  = accept && (operation == OP_CODE);
  assign start_emit = take_code && final_code;

  always_comb begin
    xf_next = xf;
    case (transform)
      XF_ROTATE: begin
        xf_next.swap    = ~xf.swap;
        xf_next.row_rev = xf.col_rev;
        xf_next.col_rev = ~xf.row_rev;
      end
      XF_FLIP: begin
        xf_next.row_rev = ~xf.row_rev;
      end
      XF_NONE: begin
        xf_next = xf;
      end
      default: begin
        xf_next = xf;
      end
    endcase
  end

  assign col_last   = (DIM_W'(col_idx) == out_cols - DIM_W'(1));
  assign issue_last = col_last && (DIM_W'(row_idx) == out_rows - DIM_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (start_emit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    case (state)
      ST_LOAD: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
      ST_EMIT: begin
        busy  = 1'b1;
        issue = 1'b1;
      end
      default: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      row_count     <= DIM_RESET;
      column_count  <= DIM_RESET;
      element_count <= '0;
      xf            <= XF_IDENTITY;
      row_idx       <= '0;
      col_idx       <= '0;
      result_valid  <= 1'b0;
      last_element  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= issue;
      last_element <= issue && issue_last;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count    <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data;
          default: begin
            row_count <= row_count;
          end
        endcase
      end
      if (load_elem) begin
        element_count <= element_count + CNT_W'(1);
      end
      if (take_code) begin
        xf <= xf_next;
      end
      if (start_emit) begin
        row_idx <= '0;
        col_idx <= '0;
      end else if (issue) begin
        if (issue_last) begin
          row_idx       <= '0;
          col_idx       <= '0;
          element_count <= '0;
          xf            <= XF_IDENTITY;
        end else if (col_last) begin
          row_idx <= row_idx + IW'(1);
          col_idx <= '0;
        end else begin
          col_idx <= col_idx + IW'(1);
        end
      end
    end
  end

  // The result dimensions are captured when emission starts and hold until the next one.
  always_ff @(posedge clk) begin
    if (start_emit) begin
      out_rows <= xf_next.swap ? cols_c : rows_c;
      out_cols <= xf_next.swap ? rows_c : cols_c;
    end
  end

  assign result_rows = out_rows;
  assign result_cols = out_cols;
  assign element_out = $signed(rd_data);

  mrf_addr_unit #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .row_idx (row_idx),
    .col_idx (col_idx),
    .xf      (xf),
    .rows    (rows_c),
    .cols    (cols_c),
    .addr    (rd_addr)
  );

  mrf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_elem),
    .wr_addr (element_count[AW-1:0]),
    .wr_data (element_in),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  `ASSERT_NEXT(a_last_gap, clk, rst, result_valid && last_element, !result_valid)
  `ASSERT_NEXT(a_final_starts, clk, rst, start && !busy && operation == OP_CODE && final_code, busy && !result_valid)
  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, element_count <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_valid_after_busy, clk, rst, result_valid, $past(busy))

endmodule
